/* rtl/lhsc_pkg.sv */
// Shared constants, types and handshake structs for the handle slot cache.
`default_nettype none
package lhsc_pkg;

  localparam int SLOTS        = 8;
  localparam int IDX_W        = 3;
  localparam int KEY_W        = 16;
  localparam int STAMP_W      = 32;
  localparam int CNT_W        = 4;
  localparam int DEFAULT_OPEN = 5;
  localparam int ACTIVE_RESET = 5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage
`default_nettype wire

/* rtl/lhsc_ctrl.sv */
// Controller state machine that sequences request capture, slot scan and commit.
`default_nettype none
module lhsc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  input  wire lhsc_pkg::status_t scan_status_i,
  output lhsc_pkg::cmd_t        cmd_o
);

  lhsc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lhsc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lhsc_pkg::ST_SCAN;
      end
      lhsc_pkg::ST_SCAN: begin
        if (scan_status_i.scan_last) state_d = lhsc_pkg::ST_COMMIT;
      end
      lhsc_pkg::ST_COMMIT: begin
        if (out_free) state_d = lhsc_pkg::ST_IDLE;
      end
      default: state_d = lhsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      lhsc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      lhsc_pkg::ST_SCAN: begin
        cmd_o.step = 1'b1;
      end
      lhsc_pkg::ST_COMMIT: begin
        // The result register must be empty or draining before it is overwritten.
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lhsc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/lhsc_dpath.sv */
// Datapath holding the slot table, use counter, scan trackers and result register.
`default_nettype none
module lhsc_dpath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lhsc_pkg::CNT_W-1:0]     cfg_data_i,
  input  wire logic [lhsc_pkg::KEY_W-1:0]     area_key_i,
  input  wire logic                           open_ok_i,
  input  wire lhsc_pkg::cmd_t                 cmd_i,
  output lhsc_pkg::status_t                   status_o,
  output logic [lhsc_pkg::IDX_W-1:0]          slot_index_o,
  output logic                                hit_o,
  output logic                                evicted_o,
  output logic [lhsc_pkg::KEY_W-1:0]          evicted_key_o,
  output logic                                granted_o
);

  localparam int IW = lhsc_pkg::IDX_W;
  localparam int KW = lhsc_pkg::KEY_W;
  localparam int SW = lhsc_pkg::STAMP_W;
  localparam int CW = lhsc_pkg::CNT_W;
  localparam logic [SW-1:0] STAMP_MAX = '1;

  logic [CW-1:0] active_q;
  logic [CW-1:0] count;
  logic [IW-1:0] last_idx;

  logic [KW-1:0] keys_q   [lhsc_pkg::SLOTS];
  logic [SW-1:0] stamps_q [lhsc_pkg::SLOTS];
  logic [SW-1:0] counter_q;

  logic [KW-1:0] req_key_q;
  logic          req_ok_q;

  logic [IW-1:0] scan_q;
  logic          hit_found_q, emp_found_q;
  logic [IW-1:0] hit_idx_q, emp_idx_q, min_idx_q;
  logic [SW-1:0] min_stamp_q;
  logic [KW-1:0] min_key_q;

  logic [KW-1:0] cur_key;
  logic [SW-1:0] cur_stamp;
  logic          cur_used;

  logic [IW-1:0] pick;
  logic          evict;
  logic          write_stamp;
  logic          clear_stamp;

  // A zero count falls back to the default; counts above the table size clamp.
  always_comb begin
    if (active_q == '0) begin
      count = CW'(lhsc_pkg::DEFAULT_OPEN);
    end else if (active_q > CW'(lhsc_pkg::SLOTS)) begin
      count = CW'(lhsc_pkg::SLOTS);
    end else begin
      count = active_q;
    end
  end
  assign last_idx = IW'(count - CW'(1));

  assign status_o.scan_last = (scan_q == last_idx);

  assign cur_key   = keys_q[scan_q];
  assign cur_stamp = stamps_q[scan_q];
  assign cur_used  = (cur_stamp != '0);

  always_comb begin
    if (hit_found_q) begin
      pick = hit_idx_q;
    end else if (emp_found_q) begin
      pick = emp_idx_q;
    end else begin
      pick = min_idx_q;
    end
  end
  assign evict       = !hit_found_q && !emp_found_q;
  assign write_stamp = cmd_i.commit && (hit_found_q || req_ok_q);
  assign clear_stamp = cmd_i.commit && evict && !req_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= CW'(lhsc_pkg::ACTIVE_RESET);
    end else if (cfg_we_i) begin
      active_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lhsc_pkg::SLOTS; i++) stamps_q[i] <= '0;
      counter_q <= SW'(1);
    end else begin
      if (write_stamp) begin
        stamps_q[pick] <= counter_q;
        if (counter_q != STAMP_MAX) counter_q <= counter_q + SW'(1);
      end else if (clear_stamp) begin
        stamps_q[pick] <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !hit_found_q && req_ok_q) begin
      keys_q[pick] <= req_key_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_key_q <= area_key_i;
      req_ok_q  <= open_ok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= '0;
      hit_found_q <= 1'b0;
      emp_found_q <= 1'b0;
    end else if (cmd_i.load) begin
      scan_q      <= '0;
      hit_found_q <= 1'b0;
      emp_found_q <= 1'b0;
    end else if (cmd_i.step) begin
      scan_q <= scan_q + IW'(1);
      if (!hit_found_q && cur_used && (cur_key == req_key_q)) hit_found_q <= 1'b1;
      if (!emp_found_q && !cur_used) emp_found_q <= 1'b1;
    end
  end

  // The first slot seeds the minimum; later slots replace it only when strictly smaller.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      if (!hit_found_q && cur_used && (cur_key == req_key_q)) hit_idx_q <= scan_q;
      if (!emp_found_q && !cur_used) emp_idx_q <= scan_q;
      if ((scan_q == '0) || (cur_stamp < min_stamp_q)) begin
        min_stamp_q <= cur_stamp;
        min_idx_q   <= scan_q;
        min_key_q   <= cur_key;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      slot_index_o  <= pick;
      hit_o         <= hit_found_q;
      evicted_o     <= evict;
      evicted_key_o <= evict ? min_key_q : '0;
      granted_o     <= hit_found_q || req_ok_q;
    end
  end

endmodule
`default_nettype wire

/* rtl/lru_handle_slot_cache_core.sv */
// Top level of the fully associative handle slot cache with timestamp LRU replacement.
// Flow: an accepted request is captured, the table is scanned one slot per cycle over
// the first n slots, where n is the effective active slot count (1 to 8), and the result
// is committed once the result register is free; a new request is taken only after that.
// Reset: all slots empty, use counter at one, active slot count at five.
`default_nettype none
module lru_handle_slot_cache_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lhsc_pkg::CNT_W-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [lhsc_pkg::KEY_W-1:0]     area_key_i,
  input  wire logic                           open_ok_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [lhsc_pkg::IDX_W-1:0]          slot_index_o,
  output logic                                hit_o,
  output logic                                evicted_o,
  output logic [lhsc_pkg::KEY_W-1:0]          evicted_key_o,
  output logic                                granted_o
);

  lhsc_pkg::cmd_t    cmd;
  lhsc_pkg::status_t status;

  lhsc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .scan_status_i (status),
    .cmd_o         (cmd)
  );

  lhsc_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .area_key_i    (area_key_i),
    .open_ok_i     (open_ok_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .slot_index_o  (slot_index_o),
    .hit_o         (hit_o),
    .evicted_o     (evicted_o),
    .evicted_key_o (evicted_key_o),
    .granted_o     (granted_o)
  );

endmodule
`default_nettype wire
